// ----- design/ngti_pkg.sv -----
// ---------------------------------------------------------------------------
// ngti_pkg
// Shared types, codes and constant tables of the grid table interpolator.
// ---------------------------------------------------------------------------
package ngti_pkg;

    // table geometry
    localparam int TABLE_ENTRIES  = 32;
    localparam int PROPERTY_COUNT = 8;
    localparam int MAX_ROUNDS     = 50;
    localparam int ENT_W          = 5;
    localparam int COL_W          = 3;
    localparam int ADDR_W         = ENT_W + COL_W;
    localparam int TABLE_DEPTH    = TABLE_ENTRIES * PROPERTY_COUNT;
    localparam int RND_W          = 7;

    // request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EVAL = 2'd1;
    localparam logic [1:0] REQ_INV  = 2'd2;

    // fixed columns
    localparam logic [COL_W-1:0] COL_TEMP = 3'd0;
    localparam logic [COL_W-1:0] COL_PRES = 3'd1;

    // register map
    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_LAST   = 1'b1;

    // result status
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_SPAN   = 2'd2,
        ST_NOCONV = 2'd3
    } t_status;

    // grid segments: upper, lower (degrees), base index, step in tenths
    localparam int SEG_COUNT = 12;
    localparam logic [9:0] SEG_HI [SEG_COUNT] =
        '{10'd250, 10'd350, 10'd360, 10'd370, 10'd372, 10'd378,
          10'd380, 10'd390, 10'd400, 10'd450, 10'd550, 10'd1000};
    localparam logic [9:0] SEG_LO [SEG_COUNT] =
        '{10'd0, 10'd250, 10'd350, 10'd360, 10'd370, 10'd372,
          10'd378, 10'd380, 10'd390, 10'd400, 10'd450, 10'd550};
    localparam logic [8:0] SEG_BASE [SEG_COUNT] =
        '{9'd0, 9'd50, 9'd100, 9'd110, 9'd130, 9'd140,
          9'd200, 9'd210, 9'd230, 9'd240, 9'd265, 9'd285};
    localparam logic [6:0] SEG_STEP [SEG_COUNT] =
        '{7'd50, 7'd20, 7'd10, 7'd5, 7'd2, 7'd1,
          7'd2, 7'd5, 7'd10, 7'd20, 7'd50, 7'd100};
    localparam logic [8:0]  GRID_TOP = 9'd330;
    localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;

    // post-multiply divide of the grid quotient
    typedef enum logic [1:0] {
        DV_NONE = 2'd0,
        DV_5    = 2'd1,
        DV_10   = 2'd2
    } t_divmode;

endpackage

// ----- design/ngti_ram.sv -----
// ---------------------------------------------------------------------------
// ngti_ram
// Generic single-clock RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module ngti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/nonuniform_grid_table_interpolator_top.sv -----
// ---------------------------------------------------------------------------
// nonuniform_grid_table_interpolator_top
// Property table over a non-uniform temperature grid with linear
// interpolation and pressure inversion by bisection.
// ---------------------------------------------------------------------------
// One item is worked at a time. A load writes the table as it is taken
// and goes straight to the hand-over. An evaluate runs the grid index
// steps (segment search, reciprocal multiply, range check), the four table
// reads, the 64x64 product built from four 32x32 partials, the restoring
// divider that divides that product by the x span (one quotient bit per
// cycle), then saturates and hands over. An invert runs search setup, the
// bisection rounds and the final probe in place of the grid index steps.
// The table sits in one 256x64 RAM with a registered read; every table
// access costs one read slot. No clearing pass runs after reset.
// ---------------------------------------------------------------------------
module nonuniform_grid_table_interpolator_top
    import ngti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_property_sel,
    input  logic [4:0]         i_entry_index,
    input  logic signed [63:0] i_operand_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_result_value,
    output logic [1:0]         o_status,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_GRID, S_GMUL, S_GIDX, S_BINIT, S_BTEST, S_BCMP, S_BHIT,
        S_BFIN, S_BFCMP, S_READ, S_DIFF, S_MUL, S_DIV, S_SAT, S_FIN
    } t_state;

    t_state                    r_state;
    logic [8:0]                r_offset;
    logic [4:0]                r_last;
    logic [COL_W-1:0]          r_sel;
    logic signed [63:0]        r_v;
    // grid index
    logic [31:0]               r_gx;
    t_divmode                  r_gmode;
    logic                      r_gneg;
    logic                      r_gover;
    logic [8:0]                r_gbase;
    logic [63:0]               r_gprod;
    // bisection
    logic signed [6:0]         r_ig;
    logic [5:0]                r_imax;
    logic [5:0]                r_imin;
    logic [RND_W-1:0]          r_rounds;
    // interpolation
    logic [COL_W-1:0]          r_ca;
    logic [COL_W-1:0]          r_cb;
    logic [ENT_W-1:0]          r_ent;
    logic [7:0]                r_cnt;
    logic signed [63:0]        r_x0, r_x1, r_y0, r_y1;
    logic [63:0]               r_num, r_den, r_dy;
    logic                      r_neg;
    logic [63:0]               r_pp;
    logic [127:0]              r_prod;
    logic [63:0]               r_rem;
    logic [127:0]              r_quo;
    logic signed [63:0]        r_res;
    t_status                   r_st;
    // output register
    logic                      r_out_valid;
    logic signed [63:0]        r_out_res;
    t_status                   r_out_st;

    logic                      in_xfer;
    logic                      cfg_wr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [63:0]               mem_rdata;
    logic signed [63:0]        pg;

    // magnitude of a - b with its sign
    function automatic logic [64:0] sdiff(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64]) begin
            sdiff = {1'b1, 64'(b) - 64'(a)};
        end else begin
            sdiff = {1'b0, 64'(a) - 64'(b)};
        end
    endfunction

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign pg         = $signed(mem_rdata);

    // register read back
    always_comb begin
        if (paddr[2] == REG_LAST) begin
            prdata = {27'd0, r_last};
        end else begin
            prdata = {23'd0, r_offset};
        end
    end

    // table memory
    assign mem_we = in_xfer && (i_req_type == REQ_LOAD);

    always_comb begin
        unique case (r_state)
            S_BTEST, S_BFIN: mem_raddr = {COL_PRES, r_ig[ENT_W-1:0]};
            S_BCMP:          mem_raddr = {COL_TEMP, r_ig[ENT_W-1:0]};
            S_READ: begin
                mem_raddr = {(r_cnt[1] ? r_cb : r_ca),
                             ENT_W'(r_ent + {4'd0, r_cnt[0]})};
            end
            default:         mem_raddr = {COL_TEMP, r_ent};
        endcase
    end

    ngti_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({i_property_sel, i_entry_index}),
        .i_wdata (i_operand_value),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // segment search and pre-divide value for the grid index
    logic [3:0]  seg;
    logic        gover;
    logic [41:0] gd;
    logic [44:0] gd5;
    logic [45:0] gd10;
    logic [63:0] gmag;
    logic [31:0] gx;
    t_divmode    gmode;

    always_comb begin
        seg = 4'd0;
        for (int s = SEG_COUNT - 1; s >= 0; s--) begin
            if (r_v <= $signed({22'd0, SEG_HI[s], 32'd0})) begin
                seg = 4'(s);
            end
        end
        gover = (r_v > $signed({22'd0, SEG_HI[SEG_COUNT-1], 32'd0}));
        gd    = r_v[41:0] - {SEG_LO[seg], 32'd0};
        gd5   = {1'b0, gd, 2'b00} + {3'd0, gd};
        gd10  = {1'b0, gd, 3'b000} + {3'd0, gd, 1'b0};
        gmag  = 64'(-r_v);
        gmode = DV_NONE;
        unique case (SEG_STEP[seg])
            7'd50:   begin gx = {22'd0, gd[41:32]}; gmode = DV_5;  end
            7'd20:   gx = {23'd0, gd[41:33]};
            7'd5:    gx = {21'd0, gd[41:31]};
            7'd2:    gx = {19'd0, gd5[44:32]};
            7'd1:    gx = {18'd0, gd10[45:32]};
            7'd100:  begin gx = {22'd0, gd[41:32]}; gmode = DV_10; end
            default: gx = {22'd0, gd[41:32]};
        endcase
        if (r_v[63]) begin
            gx    = gmag[63:32];
            gmode = DV_5;
        end
    end

    // grid index minus offset
    logic [31:0]        gq;
    logic signed [33:0] gidx;
    logic signed [33:0] goff;

    always_comb begin
        unique case (r_gmode)
            DV_5:    gq = {2'd0, r_gprod[63:34]};
            DV_10:   gq = {3'd0, r_gprod[63:35]};
            default: gq = r_gx;
        endcase
        if (r_gover) begin
            gidx = $signed({25'd0, GRID_TOP});
        end else if (r_gneg) begin
            gidx = -$signed({2'd0, gq});
        end else begin
            gidx = $signed({25'd0, r_gbase}) + $signed({2'd0, gq});
        end
        goff = gidx - $signed({25'd0, r_offset});
    end

    // operand differences for the interpolation
    logic [64:0] dden, dnum, ddy;

    always_comb begin
        dden = sdiff(r_x1, r_x0);
        dnum = sdiff(r_v, r_x0);
        ddy  = sdiff(r_y1, r_y0);
    end

    // one step of the restoring divider
    logic [64:0] div_rr;
    logic [64:0] div_sub;
    logic        div_bit;

    always_comb begin
        div_rr  = {r_rem, r_prod[127]};
        div_sub = div_rr - {1'b0, r_den};
        div_bit = !div_sub[64];
    end

    // bisection step values
    logic [6:0]        bsum_lo;
    logic [6:0]        bsum_hi;
    logic signed [6:0] bfin_ig;
    logic [RND_W-1:0]  bround;

    always_comb begin
        bsum_lo = {1'b0, r_ig[5:0]} + {1'b0, r_imin};
        bsum_hi = {1'b0, r_imax} + {1'b0, r_ig[5:0]};
        bfin_ig = (r_v < pg) ? (r_ig - 7'sd1) : r_ig;
        bround  = r_rounds + RND_W'(1);
    end

    // saturation of the interpolated result
    logic [63:0] sat_lim;
    logic        sat_over;
    logic [63:0] sat_val;

    always_comb begin
        if (!r_neg) begin
            sat_lim = 64'h7FFF_FFFF_FFFF_FFFF - 64'(r_y0);
        end else begin
            sat_lim = 64'(r_y0) - 64'h8000_0000_0000_0000;
        end
        sat_over = (r_quo[127:64] != 64'd0) || (r_quo[63:0] > sat_lim);
        if (!r_neg) begin
            sat_val = sat_over ? 64'h7FFF_FFFF_FFFF_FFFF : 64'(r_y0) + r_quo[63:0];
        end else begin
            sat_val = sat_over ? 64'h8000_0000_0000_0000 : 64'(r_y0) - r_quo[63:0];
        end
    end

    // sequencer, registers and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= 9'd310;
            r_last      <= 5'd20;
            r_out_valid <= 1'b0;
        end else begin
            // register writes
            if (cfg_wr) begin
                if (paddr[2] == REG_LAST) begin
                    r_last <= pwdata[4:0];
                end else begin
                    r_offset <= pwdata[8:0];
                end
            end

            // result transfer, unless a new result is loaded in its place
            if (r_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sel <= i_property_sel;
                        r_v   <= i_operand_value;
                        r_res <= 64'sd0;
                        r_st  <= ST_OK;
                        unique case (i_req_type)
                            REQ_LOAD: r_state <= S_FIN;
                            REQ_EVAL: r_state <= S_GRID;
                            REQ_INV:  r_state <= S_BINIT;
                            default: begin
                                r_st    <= ST_RANGE;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_GRID: begin
                    r_gx    <= gx;
                    r_gmode <= gmode;
                    r_gneg  <= r_v[63];
                    r_gover <= gover;
                    r_gbase <= SEG_BASE[seg];
                    r_state <= S_GMUL;
                end
                S_GMUL: begin
                    r_gprod <= r_gx * RECIP5;
                    r_state <= S_GIDX;
                end
                S_GIDX: begin
                    // every 3-bit column lies in the table
                    if (goff < 34'sd0 || goff > 34'(TABLE_ENTRIES - 2)) begin
                        r_st    <= ST_RANGE;
                        r_state <= S_FIN;
                    end else begin
                        r_ent   <= goff[ENT_W-1:0];
                        r_ca    <= COL_TEMP;
                        r_cb    <= r_sel;
                        r_cnt   <= 8'd0;
                        r_state <= S_READ;
                    end
                end
                S_BINIT: begin
                    r_imax   <= {1'b0, r_last};
                    r_imin   <= 6'd0;
                    r_ig     <= {3'b000, r_last[4:1]};
                    r_rounds <= '0;
                    r_state  <= S_BTEST;
                end
                S_BTEST: begin
                    if ($signed({1'b0, r_imax}) - r_ig > 7'sd1) begin
                        r_state <= S_BCMP;
                    end else begin
                        r_state <= S_BFIN;
                    end
                end
                S_BCMP: begin
                    if (r_v == pg) begin
                        r_state <= S_BHIT;
                    end else begin
                        if (r_v < pg) begin
                            r_imax <= r_ig[5:0];
                            r_ig   <= {1'b0, bsum_lo[6:1]};
                        end else begin
                            r_imin <= r_ig[5:0];
                            r_ig   <= {1'b0, bsum_hi[6:1]};
                        end
                        r_rounds <= bround;
                        if (bround > RND_W'(MAX_ROUNDS)) begin
                            r_st    <= ST_NOCONV;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_BTEST;
                        end
                    end
                end
                S_BHIT: begin
                    r_res   <= pg;
                    r_state <= S_FIN;
                end
                S_BFIN: begin
                    r_state <= S_BFCMP;
                end
                S_BFCMP: begin
                    if (bfin_ig < 7'sd0 || bfin_ig > 7'(TABLE_ENTRIES - 2)) begin
                        r_st    <= ST_RANGE;
                        r_state <= S_FIN;
                    end else begin
                        r_ent   <= bfin_ig[ENT_W-1:0];
                        r_ca    <= COL_PRES;
                        r_cb    <= COL_TEMP;
                        r_cnt   <= 8'd0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // read issued at count k returns at count k+1
                    unique case (r_cnt[2:0])
                        3'd1:    r_x0 <= pg;
                        3'd2:    r_x1 <= pg;
                        3'd3:    r_y0 <= pg;
                        3'd4:    r_y1 <= pg;
                        default: ;
                    endcase
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'd4) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_den  <= dden[63:0];
                    r_num  <= dnum[63:0];
                    r_dy   <= ddy[63:0];
                    r_neg  <= (dnum[64] != ddy[64]) != dden[64];
                    r_prod <= 128'd0;
                    r_cnt  <= 8'd0;
                    if (dden[63:0] == 64'd0) begin
                        r_st    <= ST_SPAN;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // partial product k formed at count k, added at k+1
                    unique case (r_cnt[2:0])
                        3'd0:    r_pp <= r_num[31:0] * r_dy[31:0];
                        3'd1:    r_pp <= r_num[31:0] * r_dy[63:32];
                        3'd2:    r_pp <= r_num[63:32] * r_dy[31:0];
                        3'd3:    r_pp <= r_num[63:32] * r_dy[63:32];
                        default: ;
                    endcase
                    unique case (r_cnt[2:0])
                        3'd1:    r_prod <= r_prod + {64'd0, r_pp};
                        3'd2,
                        3'd3:    r_prod <= r_prod + {32'd0, r_pp, 32'd0};
                        3'd4:    r_prod <= r_prod + {r_pp, 64'd0};
                        default: ;
                    endcase
                    if (r_cnt == 8'd4) begin
                        r_cnt   <= 8'd0;
                        r_rem   <= 64'd0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 8'd1;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_bit ? div_sub[63:0] : div_rr[63:0];
                    r_quo  <= {r_quo[126:0], div_bit};
                    r_prod <= {r_prod[126:0], 1'b0};
                    r_cnt  <= r_cnt + 8'd1;
                    if (r_cnt == 8'd127) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_res   <= $signed(sat_val);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= (r_st == ST_OK) ? r_res : 64'sd0;
                        r_out_st    <= r_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_st;

`ifndef SYNTHESIS
    // table writes happen only when a load is taken in idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE))
        else $error("table write outside idle");

    // a taken request blocks the next one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("request taken while busy");

    // interpolation never starts on the last entry
    a_pair_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_ent != ENT_W'(TABLE_ENTRIES - 1)))
        else $error("entry pair leaves the table");
`endif

endmodule
